>>> rtl/psgt_pkg.sv
// Shared constants and types for the pausable scaled game timer.
package psgt_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int RATE_W        = 16;
    localparam int TARGET_W      = 48;
    localparam int APB_DATA_W    = 64;
    localparam int APB_ADDR_W    = 4;
    localparam int REQ_W         = 3;

    // Q8.8 value of 1.0 and the number of fraction bits.
    localparam logic [RATE_W-1:0] RATE_ONE  = 16'd256;
    localparam int                RATE_FRAC = 8;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_UPDATE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_START   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PAUSE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_UNPAUSE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FFWD    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REWIND  = 3'd5;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd6;

    // Register indexes, taken from paddr[3].
    localparam logic CFG_IDX_RATE   = 1'b0;
    localparam logic CFG_IDX_TARGET = 1'b1;

    typedef struct packed {
        logic paused;
        logic started;
    } t_flags;

endpackage

>>> rtl/psgt_cfg.sv
// APB register file holding the rate multiplier and the countdown target.
module psgt_cfg #(
    parameter int TIME_BITS = psgt_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psgt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [psgt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [psgt_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            i_rate_reload,
    output logic [psgt_pkg::RATE_W-1:0]     o_rate_mul,
    output logic [TIME_BITS-1:0]            o_target
);
    import psgt_pkg::*;

    logic [RATE_W-1:0]    r_rate_mul;
    logic [TIME_BITS-1:0] r_target;
    logic                 w_write;
    logic                 w_idx;
    logic [RATE_W-1:0]    w_rate_in;
    logic [TARGET_W-1:0]  w_target_in;

    assign pready      = 1'b1;
    assign w_write     = psel && penable && pwrite && pready;
    assign w_idx       = paddr[3];
    assign w_rate_in   = pwdata[RATE_W-1:0];
    assign w_target_in = pwdata[TARGET_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_mul <= RATE_ONE;
            r_target   <= '0;
        end else begin
            // A start request puts the time scale back to 1.0.
            if (i_rate_reload) begin
                r_rate_mul <= RATE_ONE;
            end else if (w_write && w_idx == CFG_IDX_RATE && w_rate_in != '0) begin
                r_rate_mul <= w_rate_in;
            end
            if (w_write && w_idx == CFG_IDX_TARGET) begin
                r_target <= TIME_BITS'(w_target_in);
            end
        end
    end

    always_comb begin
        unique case (w_idx)
            CFG_IDX_RATE:   prdata = APB_DATA_W'(r_rate_mul);
            CFG_IDX_TARGET: prdata = APB_DATA_W'(r_target);
            default:        prdata = '0;
        endcase
    end

    assign o_rate_mul = r_rate_mul;
    assign o_target   = r_target;

endmodule

>>> rtl/psgt_core.sv
// Timer state registers and the single-pass next-state logic for one request.
module psgt_core #(
    parameter int TIME_BITS = psgt_pkg::TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [psgt_pkg::REQ_W-1:0]   i_req,
    input  logic [TIME_BITS-1:0]         i_tv,
    input  logic [psgt_pkg::RATE_W-1:0]  i_rate_mul,
    output logic                         o_rate_reload,
    output logic [TIME_BITS-1:0]         o_acc,
    output logic [TIME_BITS-1:0]         o_prior,
    output logic [TIME_BITS-1:0]         o_delta,
    output psgt_pkg::t_flags             o_flags
);
    import psgt_pkg::*;

    localparam int PROD_W = TIME_BITS + RATE_W;

    logic [TIME_BITS-1:0] r_acc, n_acc;
    logic [TIME_BITS-1:0] r_prior, n_prior;
    logic [TIME_BITS-1:0] r_mark, n_mark;
    logic [TIME_BITS-1:0] r_delta, n_delta;
    t_flags               r_flags, n_flags;
    logic                 r_pend, n_pend;

    logic [TIME_BITS-1:0] w_mark_eff;
    logic [TIME_BITS-1:0] w_diff;
    logic [PROD_W-1:0]    w_prod;
    logic [TIME_BITS-1:0] w_step;

    // A sample earlier than the marker gives a zero step.
    assign w_mark_eff = (i_tv < r_mark) ? i_tv : r_mark;
    assign w_diff     = i_tv - w_mark_eff;
    assign w_prod     = PROD_W'(w_diff) * PROD_W'(i_rate_mul);
    assign w_step     = w_prod[TIME_BITS+RATE_FRAC-1:RATE_FRAC];

    always_comb begin
        n_acc   = r_acc;
        n_prior = r_prior;
        n_mark  = r_mark;
        n_delta = r_delta;
        n_flags = r_flags;
        n_pend  = r_pend;
        unique case (i_req)
            REQ_UPDATE: begin
                n_mark = i_tv;
                if (r_flags.paused) begin
                    n_delta = '0;
                    if (r_pend) begin
                        n_flags.paused = 1'b0;
                        n_pend         = 1'b0;
                    end
                end else begin
                    n_prior = r_acc;
                    n_acc   = r_acc + w_step;
                    n_delta = w_step;
                    n_pend  = 1'b0;
                end
            end
            REQ_START: begin
                n_acc           = '0;
                n_prior         = '0;
                n_delta         = '0;
                n_mark          = i_tv;
                n_flags.paused  = 1'b0;
                n_flags.started = 1'b1;
                n_pend          = 1'b1;
            end
            REQ_PAUSE:   n_flags.paused = 1'b1;
            REQ_UNPAUSE: n_pend = 1'b1;
            REQ_FFWD:    n_acc = r_acc + i_tv;
            REQ_REWIND:  n_acc = (i_tv < r_acc) ? r_acc - i_tv : '0;
            REQ_CLEAR:   n_acc = '0;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_prior <= '0;
            r_mark  <= '0;
            r_delta <= '0;
            r_flags <= '0;
            r_pend  <= 1'b1;
        end else if (i_fire) begin
            r_acc   <= n_acc;
            r_prior <= n_prior;
            r_mark  <= n_mark;
            r_delta <= n_delta;
            r_flags <= n_flags;
            r_pend  <= n_pend;
        end
    end

    assign o_rate_reload = i_fire && (i_req == REQ_START);
    assign o_acc         = r_acc;
    assign o_prior       = r_prior;
    assign o_delta       = r_delta;
    assign o_flags       = r_flags;

endmodule

>>> rtl/pausable_scaled_game_timer.sv
// Top level of the pausable scaled game timer: handshake, input register and result.
//
// Requests arrive on the input channel (i_in_valid / o_in_ready) with a request
// code and a 48-bit time value. Each request yields exactly one result on the
// output channel (o_out_valid / i_out_ready): elapsed time, previous time,
// step delta, paused and started flags, and the countdown remaining.
// A request is held in an input register, then applied to the timer state
// in a single pass (one 48x16 scale multiply and an add); the updated state
// registers are the result. One request per cycle is sustained while
// results are taken. While a result waits, one more request can be taken
// into the input register; a stall longer than that drops o_in_ready until
// the result is taken. The APB port sets the Q8.8 rate multiplier
// (address 0) and the countdown target (address 8); the user must make
// writes only while the timer is idle; the block does not enforce it.
// A synchronous reset clears both channels, sets the multiplier to 1.0, the
// countdown target and all time state to zero, and arms a pending unpause.
module pausable_scaled_game_timer #(
    parameter int TIME_BITS = psgt_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [psgt_pkg::REQ_W-1:0]      i_req_type,
    input  logic [TIME_BITS-1:0]            i_time_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [TIME_BITS-1:0]            o_elapsed_time,
    output logic [TIME_BITS-1:0]            o_previous_time,
    output logic [TIME_BITS-1:0]            o_step_delta,
    output logic                            o_paused_flag,
    output logic                            o_started_flag,
    output logic [TIME_BITS-1:0]            o_countdown_left,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psgt_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [psgt_pkg::APB_DATA_W-1:0] pwdata,
    output logic [psgt_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import psgt_pkg::*;

    logic                 r_in_valid;
    logic [REQ_W-1:0]     r_req;
    logic [TIME_BITS-1:0] r_tv;
    logic                 r_out_valid;
    logic                 w_advance;
    logic                 w_reload;
    logic [RATE_W-1:0]    w_rate_mul;
    logic [TIME_BITS-1:0] w_target;
    logic [TIME_BITS-1:0] w_acc;
    t_flags               w_flags;

    // The held request moves into the state when the result slot is free.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req <= i_req_type;
            r_tv  <= i_time_value;
        end
    end

    psgt_cfg #(
        .TIME_BITS(TIME_BITS)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_rate_reload (w_reload),
        .o_rate_mul    (w_rate_mul),
        .o_target      (w_target)
    );

    psgt_core #(
        .TIME_BITS(TIME_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_advance),
        .i_req         (r_req),
        .i_tv          (r_tv),
        .i_rate_mul    (w_rate_mul),
        .o_rate_reload (w_reload),
        .o_acc         (w_acc),
        .o_prior       (o_previous_time),
        .o_delta       (o_step_delta),
        .o_flags       (w_flags)
    );

    assign o_out_valid      = r_out_valid;
    assign o_elapsed_time   = w_acc;
    assign o_paused_flag    = w_flags.paused;
    assign o_started_flag   = w_flags.started;
    assign o_countdown_left = (w_target > w_acc) ? w_target - w_acc : '0;

endmodule

>>> rtl/psgt_checker.sv
// Port-level assertions for the pausable scaled game timer, bound to the top level.
module psgt_port_checks #(
    parameter int TIME_BITS = psgt_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_ready,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic [TIME_BITS-1:0]            o_elapsed_time,
    input  logic [TIME_BITS-1:0]            o_previous_time,
    input  logic [TIME_BITS-1:0]            o_step_delta,
    input  logic                            o_paused_flag,
    input  logic                            o_started_flag,
    input  logic [TIME_BITS-1:0]            o_countdown_left
);

    // A stalled result keeps its values.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_elapsed_time)
            && $stable(o_step_delta) && $stable(o_countdown_left))
        else $error("result changed while stalled");

    // The input side only backs up when the result slot is blocked.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input not ready without an output stall");

    // Only reset takes the started flag away.
    a_started_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(o_started_flag))
        else $error("started flag fell without reset");

    // The first start shows a cleared, running timer.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(o_started_flag) |-> o_out_valid
            && o_elapsed_time == '0 && o_previous_time == '0
            && o_step_delta == '0 && !o_paused_flag)
        else $error("start did not clear the timer state");

endmodule

bind pausable_scaled_game_timer psgt_port_checks #(.TIME_BITS(TIME_BITS)) u_psgt_checker (.*);

>>> tb/psgt_checker.sv
// Checker for the pausable scaled game timer: predicts every result and compares it.
`timescale 1ns / 1ps

module psgt_checker
    import psgt_pkg::*;
#(
    parameter int TB = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [TB-1:0]         i_time_value,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [TB-1:0]         i_elapsed_time,
    input  logic [TB-1:0]         i_previous_time,
    input  logic [TB-1:0]         i_step_delta,
    input  logic                  i_paused_flag,
    input  logic                  i_started_flag,
    input  logic [TB-1:0]         i_countdown_left,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [TB-1:0] elapsed;
        logic [TB-1:0] previous;
        logic [TB-1:0] delta;
        logic          paused;
        logic          started;
        logic [TB-1:0] countdown;
    } t_timer_result;

    // Predicted configuration and timer state.
    logic [RATE_W-1:0] rate_q88;
    logic [TB-1:0]     target_ms;
    logic [TB-1:0]     total_ms;
    logic [TB-1:0]     prior_ms;
    logic [TB-1:0]     marker;
    logic [TB-1:0]     delta_ms;
    logic              paused;
    logic              unpause_armed;
    logic              started;

    t_timer_result expected_results[$];

    task automatic reset_timer();
        rate_q88      = RATE_ONE;
        target_ms     = '0;
        total_ms      = '0;
        prior_ms      = '0;
        marker        = '0;
        delta_ms      = '0;
        paused        = 1'b0;
        unpause_armed = 1'b1;
        started       = 1'b0;
    endtask

    task automatic apply_request(input logic [REQ_W-1:0] kind, input logic [TB-1:0] tv);
        logic [TB-1:0] diff;
        logic [63:0]   product;
        logic [TB-1:0] step;
        case (kind)
            REQ_UPDATE: begin
                if (paused) begin
                    marker = tv;
                    if (unpause_armed) begin
                        paused        = 1'b0;
                        unpause_armed = 1'b0;
                    end
                    delta_ms = '0;
                end else begin
                    // A clock that went backward contributes nothing.
                    if (tv < marker) marker = tv;
                    diff          = tv - marker;
                    product       = {{(64-TB){1'b0}}, diff} * {48'b0, rate_q88};
                    step          = product[RATE_FRAC +: TB];
                    prior_ms      = total_ms;
                    total_ms      = total_ms + step;
                    delta_ms      = step;
                    marker        = tv;
                    unpause_armed = 1'b0;
                end
            end
            REQ_START: begin
                total_ms      = '0;
                prior_ms      = '0;
                delta_ms      = '0;
                marker        = tv;
                paused        = 1'b0;
                unpause_armed = 1'b1;
                rate_q88      = RATE_ONE;
                started       = 1'b1;
            end
            REQ_PAUSE:   paused = 1'b1;
            REQ_UNPAUSE: unpause_armed = 1'b1;
            REQ_FFWD:    total_ms = total_ms + tv;
            REQ_REWIND:  total_ms = (tv < total_ms) ? total_ms - tv : '0;
            REQ_CLEAR:   total_ms = '0;
            default: ;
        endcase
    endtask

    function automatic t_timer_result snapshot();
        t_timer_result r;
        r.elapsed   = total_ms;
        r.previous  = prior_ms;
        r.delta     = delta_ms;
        r.paused    = paused;
        r.started   = started;
        r.countdown = (target_ms > total_ms) ? target_ms - total_ms : '0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_timer_result want;
        if (!i_rst_n) begin
            reset_timer();
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[3] == CFG_IDX_RATE) begin
                    // A zero multiplier is refused.
                    if (i_pwdata[RATE_W-1:0] != '0) rate_q88 = i_pwdata[RATE_W-1:0];
                end else begin
                    target_ms = i_pwdata[TB-1:0];
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_request(i_req_type, i_time_value);
                expected_results.push_back(snapshot());
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transaction with no request waiting", $time);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("elapsed_time", 64'(want.elapsed), 64'(i_elapsed_time));
                    check_field("previous_time", 64'(want.previous), 64'(i_previous_time));
                    check_field("step_delta", 64'(want.delta), 64'(i_step_delta));
                    check_field("paused_flag", 64'(want.paused), 64'(i_paused_flag));
                    check_field("started_flag", 64'(want.started), 64'(i_started_flag));
                    check_field("countdown_left", 64'(want.countdown), 64'(i_countdown_left));
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> tb/tb_top.sv
// Testbench top for the pausable scaled game timer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import psgt_pkg::*;

    localparam int TW = TIME_BITS_DEF;
    localparam logic [REQ_W-1:0]      REQ_UNUSED  = 3'd7;
    localparam logic [APB_ADDR_W-1:0] ADDR_RATE   = 4'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_TARGET = 4'd8;
    localparam logic [TW-1:0]         TIME_MAX    = '1;
    localparam int CYCLE_LIMIT = 300000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  in_valid    = 1'b0;
    logic [REQ_W-1:0]      req_type    = '0;
    logic [TW-1:0]         time_value  = '0;
    logic                  out_ready   = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;

    logic                  in_ready;
    logic                  out_valid;
    logic [TW-1:0]         elapsed_time;
    logic [TW-1:0]         previous_time;
    logic [TW-1:0]         step_delta;
    logic                  paused_flag;
    logic                  started_flag;
    logic [TW-1:0]         countdown_left;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int            fail_count;
    int            pending;
    int            send_idle_pct = 24;
    int            recv_idle_pct = 83;
    int            cycles        = 0;
    logic [TW-1:0] wall_clock    = '0;

    always #1 i_clk = ~i_clk;

    pausable_scaled_game_timer #(.TIME_BITS(TW)) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_req_type       (req_type),
        .i_time_value     (time_value),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_elapsed_time   (elapsed_time),
        .o_previous_time  (previous_time),
        .o_step_delta     (step_delta),
        .o_paused_flag    (paused_flag),
        .o_started_flag   (started_flag),
        .o_countdown_left (countdown_left),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    psgt_checker #(.TB(TW)) u_timer_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_req_type       (req_type),
        .i_time_value     (time_value),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_elapsed_time   (elapsed_time),
        .i_previous_time  (previous_time),
        .i_step_delta     (step_delta),
        .i_paused_flag    (paused_flag),
        .i_started_flag   (started_flag),
        .i_countdown_left (countdown_left),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_pready         (pready),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [TW-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[TW-1:0];
    endfunction

    // All stimulus tasks are entered and left just after a falling edge.
    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [TW-1:0] tv);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        time_value <= tv;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly a forward-running clock with pauses and adjustments mixed in;
    // a share of samples is arbitrary so backward clocks and wraps occur.
    task automatic run_random(input int count);
        int            pick;
        logic [TW-1:0] amount;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0) amount = rand_time();
            else amount = TW'($urandom_range(0, 100000));
            if (pick < 50) begin
                if ($urandom_range(0, 19) == 0)
                    wall_clock = wall_clock + (rand_time() >> $urandom_range(0, 47));
                else
                    wall_clock = wall_clock + TW'($urandom_range(0, 3000));
                if ($urandom_range(0, 11) == 0) send_req(REQ_UPDATE, rand_time());
                else send_req(REQ_UPDATE, wall_clock);
            end else if (pick < 60) begin
                send_req(REQ_PAUSE, rand_time());
            end else if (pick < 70) begin
                send_req(REQ_UNPAUSE, rand_time());
            end else if (pick < 78) begin
                send_req(REQ_FFWD, amount);
            end else if (pick < 86) begin
                send_req(REQ_REWIND, amount);
            end else if (pick < 90) begin
                send_req(REQ_CLEAR, rand_time());
            end else if (pick < 93) begin
                if ($urandom_range(0, 3) == 0) wall_clock = rand_time();
                send_req(REQ_START, wall_clock);
            end else if (pick < 96) begin
                send_req(REQ_UNUSED, rand_time());
            end else begin
                send_req(REQ_UPDATE, wall_clock - TW'($urandom_range(1, 5000)));
            end
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The zero write must leave the maximum multiplier in place.
        apb_write(ADDR_RATE, 64'(16'hFFFF));
        apb_write(ADDR_RATE, '0);
        apb_write(ADDR_TARGET, 64'(TIME_MAX));

        send_req(REQ_UPDATE, TIME_MAX);
        send_req(REQ_UPDATE, 48'd50);
        send_req(REQ_START, 48'd1000);
        send_req(REQ_UPDATE, 48'd1500);
        send_req(REQ_PAUSE, '0);
        send_req(REQ_UPDATE, 48'd2000);
        send_req(REQ_UNPAUSE, TIME_MAX);
        send_req(REQ_UPDATE, 48'd2500);
        send_req(REQ_UPDATE, 48'd3000);
        send_req(REQ_FFWD, TIME_MAX);
        send_req(REQ_REWIND, TIME_MAX);
        send_req(REQ_FFWD, 48'd12345);
        send_req(REQ_REWIND, 48'd100);
        send_req(REQ_CLEAR, TIME_MAX);
        send_req(REQ_UNUSED, rand_time());
        send_req(REQ_UPDATE, TIME_MAX);
        send_req(REQ_UPDATE, '0);
        send_req(REQ_PAUSE, '0);
        send_req(REQ_PAUSE, '0);
        send_req(REQ_UPDATE, 48'd10);
        send_req(REQ_START, TIME_MAX);
        send_req(REQ_UPDATE, '0);
        send_req(REQ_UPDATE, 48'd5000);
        drain();

        wall_clock = 48'd5000;
        apb_write(ADDR_RATE, 64'd1);
        apb_write(ADDR_TARGET, 64'($urandom_range(0, 1 << 24)));
        run_random(200);
        // Hold the sender back until every result is in.
        drain();
        run_random(250);
        drain();

        send_idle_pct = 83;
        recv_idle_pct = 24;
        apb_write(ADDR_RATE, 64'(16'hFFFF));
        apb_write(ADDR_TARGET, '0);
        run_random(450);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apb_write(ADDR_RATE, 64'($urandom_range(1, 65535)));
        apb_write(ADDR_TARGET, 64'(rand_time() >> $urandom_range(0, 40)));
        run_random(450);
        drain();

        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
